/* rtl/multi_watchdog_supervisor_macros.svh */
// Assertion macros shared by the watchdog supervisor RTL.
// Every macro expects signals named clk and rst_n in the using module.
`ifndef MULTI_WATCHDOG_SUPERVISOR_MACROS_SVH
`define MULTI_WATCHDOG_SUPERVISOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mws_pkg.sv */
// Shared types and constants of the watchdog supervisor.
// No dependencies; every other RTL file but the macro header imports this package.
package mws_pkg;

  localparam int OP_W     = 3;
  localparam int ID_W     = 32;
  localparam int TICK_W   = 64;
  localparam int LIMIT_W  = 32;
  localparam int DOMF_W   = 4;
  localparam int HEALTH_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ARM    = 3'd0;
  localparam logic [OP_W-1:0] OP_KICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_POLL   = 3'd2;
  localparam logic [OP_W-1:0] OP_REPORT = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  // Health codes.
  localparam logic [HEALTH_W-1:0] HEALTH_OK     = 2'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_FAILED = 2'd1;

  // One input item.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     dog_id;
    logic [TICK_W-1:0]   now_tick;
    logic [LIMIT_W-1:0]  limit_ticks;
    logic [DOMF_W-1:0]   fault_domain;
    logic [HEALTH_W-1:0] new_health;
  } item_t;

  // One entry of the slot table.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] timeout;
    logic [TICK_W-1:0]  last_kick;
    logic [DOMF_W-1:0]  domain;
  } slot_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted item, rewind the scan
    logic prime;     // first slot read of a scan
    logic scan_adv;  // move the scan to the next slot
    logic commit;    // apply updates and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the slot under check matches the current operation
    logic chk_last;  // the slot under check is the last one
    logic out_free;  // the result register can take a new result
  } sts_t;

endpackage

/* rtl/mws_in_if.sv */
// Input channel of the watchdog supervisor: valid/ready plus one item.
// Depends on mws_pkg for the field widths.
interface mws_in_if;
  import mws_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ID_W-1:0]     dog_id;
  logic [TICK_W-1:0]   now_tick;
  logic [LIMIT_W-1:0]  limit_ticks;
  logic [DOMF_W-1:0]   fault_domain;
  logic [HEALTH_W-1:0] new_health;

  modport source (
    output valid, op, dog_id, now_tick, limit_ticks, fault_domain, new_health,
    input  ready
  );

  modport sink (
    input  valid, op, dog_id, now_tick, limit_ticks, fault_domain, new_health,
    output ready
  );
endinterface

/* rtl/mws_out_if.sv */
// Result channel of the watchdog supervisor: valid/ready plus one result.
// Depends on mws_pkg for the field widths.
interface mws_out_if;
  import mws_pkg::*;

  logic                valid;
  logic                ready;
  logic                ok;
  logic [ID_W-1:0]     expired_id;
  logic [DOMF_W-1:0]   expired_domain;
  logic [HEALTH_W-1:0] health;

  modport source (
    output valid, ok, expired_id, expired_domain, health,
    input  ready
  );

  modport sink (
    input  valid, ok, expired_id, expired_domain, health,
    output ready
  );
endinterface

/* rtl/mws_datapath.sv */
// Datapath of the watchdog supervisor: item register, slot memory, armed
// bits, health store, slot scan and result register. Uses mws_pkg, mws_out_if.
`include "multi_watchdog_supervisor_macros.svh"

module mws_datapath #(
  parameter int NUM_SLOTS   = 8,
  parameter int NUM_DOMAINS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mws_pkg::item_t   item,
  input  mws_pkg::cmd_t    cmd,
  output mws_pkg::sts_t    sts,
  mws_out_if.source        out_ch
);
  import mws_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int DOM_W  = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [DOMF_W:0]   DOM_CNT   = (DOMF_W + 1)'(NUM_DOMAINS);

  item_t               item_r;
  slot_t               slot_mem [NUM_SLOTS];
  slot_t               rd_data_r;
  slot_t               wr_entry;
  logic [SLOT_W-1:0]   rd_idx_r;
  logic [SLOT_W-1:0]   chk_idx_r;
  logic [NUM_SLOTS-1:0] armed_r;
  logic [HEALTH_W-1:0] health_r [NUM_DOMAINS];

  logic                out_valid_r;
  logic                out_ok_r;
  logic [ID_W-1:0]     out_id_r;
  logic [DOMF_W-1:0]   out_dom_r;
  logic [HEALTH_W-1:0] out_health_r;

  logic                res_ok;
  logic [ID_W-1:0]     res_id;
  logic [DOMF_W-1:0]   res_dom;
  logic [HEALTH_W-1:0] res_health;

  logic                chk_armed;
  logic                id_eq;
  logic [TICK_W-1:0]   elapsed;
  logic                expired;
  logic                hit;
  logic                item_dom_ok;
  logic                slot_dom_ok;
  logic [DOM_W-1:0]    item_dom_idx;
  logic [DOM_W-1:0]    slot_dom_idx;
  logic                scan_rd;

  // Capture the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
  end

  // Scan address: rewinds on a new item and stops at the last slot.
  assign scan_rd = cmd.prime | cmd.scan_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.load) begin
      rd_idx_r <= '0;
    end else if (scan_rd && (rd_idx_r != SLOT_LAST)) begin
      rd_idx_r <= rd_idx_r + SLOT_W'(1);
    end
  end

  // Registered read of the slot memory; the data and its index hold while
  // the controller decides on the slot under check.
  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rd_data_r <= slot_mem[rd_idx_r];
      chk_idx_r <= rd_idx_r;
    end
  end

  // Match logic for the slot under check.
  assign chk_armed = armed_r[chk_idx_r];
  assign id_eq     = (rd_data_r.id == item_r.dog_id);
  assign elapsed   = item_r.now_tick - rd_data_r.last_kick;
  assign expired   = (elapsed > {{(TICK_W - LIMIT_W){1'b0}}, rd_data_r.timeout});

  always_comb begin
    case (item_r.op)
      OP_ARM:  hit = !chk_armed || id_eq;
      OP_KICK: hit = chk_armed && id_eq;
      OP_POLL: hit = chk_armed && expired;
      default: hit = 1'b0;
    endcase
  end

  assign sts.hit      = hit;
  assign sts.chk_last = (chk_idx_r == SLOT_LAST);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  // Domain checks and indexes.
  assign item_dom_ok  = ({1'b0, item_r.fault_domain} < DOM_CNT);
  assign slot_dom_ok  = ({1'b0, rd_data_r.domain} < DOM_CNT);
  assign item_dom_idx = item_r.fault_domain[DOM_W-1:0];
  assign slot_dom_idx = rd_data_r.domain[DOM_W-1:0];

  // Entry written back on arm (fresh entry) or kick (new kick tick).
  always_comb begin
    if (item_r.op == OP_ARM) begin
      wr_entry.id        = item_r.dog_id;
      wr_entry.timeout   = item_r.limit_ticks;
      wr_entry.last_kick = item_r.now_tick;
      wr_entry.domain    = item_r.fault_domain;
    end else begin
      wr_entry           = rd_data_r;
      wr_entry.last_kick = item_r.now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && hit && ((item_r.op == OP_ARM) || (item_r.op == OP_KICK))) begin
      slot_mem[chk_idx_r] <= wr_entry;
    end
  end

  // Armed bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else if (cmd.commit && hit && (item_r.op == OP_ARM)) begin
      armed_r[chk_idx_r] <= 1'b1;
    end
  end

  // Health store: written by report and by a poll that finds an expiry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < NUM_DOMAINS; d++) begin
        health_r[d] <= HEALTH_OK;
      end
    end else if (cmd.commit) begin
      if ((item_r.op == OP_REPORT) && item_dom_ok) begin
        health_r[item_dom_idx] <= item_r.new_health;
      end else if ((item_r.op == OP_POLL) && hit && slot_dom_ok) begin
        health_r[slot_dom_idx] <= HEALTH_FAILED;
      end
    end
  end

  // Result of the current item.
  always_comb begin
    res_ok     = 1'b0;
    res_id     = '0;
    res_dom    = '0;
    res_health = HEALTH_OK;
    case (item_r.op) inside
      OP_ARM, OP_KICK: begin
        res_ok = hit;
      end
      OP_POLL: begin
        if (hit) begin
          res_ok     = 1'b1;
          res_id     = rd_data_r.id;
          res_dom    = rd_data_r.domain;
          res_health = HEALTH_FAILED;
        end
      end
      OP_REPORT: begin
        res_ok = item_dom_ok;
      end
      OP_QUERY: begin
        res_ok     = item_dom_ok;
        res_health = item_dom_ok ? health_r[item_dom_idx] : HEALTH_FAILED;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Result register; a result waits here until its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_ok_r     <= res_ok;
      out_id_r     <= res_id;
      out_dom_r    <= res_dom;
      out_health_r <= res_health;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.expired_id     = out_id_r;
  assign out_ch.expired_domain = out_dom_r;
  assign out_ch.health         = out_health_r;

  // A successful arm leaves its slot armed.
  `MWS_ASSERT_NXT(a_arm_sets_armed, cmd.commit && hit && (item_r.op == OP_ARM), armed_r[$past(chk_idx_r)], "arm did not set the armed bit")
  // An expiry on a valid domain marks that domain failed.
  `MWS_ASSERT_NXT(a_poll_marks_failed, cmd.commit && hit && (item_r.op == OP_POLL) && slot_dom_ok, health_r[$past(slot_dom_idx)] == HEALTH_FAILED, "expired domain not marked failed")
  // Slots are never disarmed outside reset.
  `MWS_ASSERT_IMP(a_armed_monotonic, $past(rst_n), $countones(armed_r) >= $past($countones(armed_r)), "armed slot count decreased")

endmodule

/* rtl/mws_ctrl.sv */
// Controller of the watchdog supervisor: accepts items and sequences the
// slot scan and the commit step. Uses mws_pkg.
module mws_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [mws_pkg::OP_W-1:0]  in_op,
  output logic                      in_ready,
  output mws_pkg::cmd_t             cmd,
  input  mws_pkg::sts_t             sts
);
  import mws_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op inside {OP_ARM, OP_KICK, OP_POLL}) begin
            state_nxt = ST_PRIME;
          end else begin
            state_nxt = ST_COMMIT;
          end
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit || sts.chk_last) begin
          state_nxt = ST_COMMIT;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/multi_watchdog_supervisor.sv */
// Watchdog supervisor: a table of NUM_SLOTS watchdog slots and a health store
// of NUM_DOMAINS fault domains. Arm, kick and poll walk the slots in order
// through the single read port of the slot memory, one slot per cycle, and stop
// at the first match or at the last slot; a result is committed only when the
// result register can take it. Report, query and the unused op codes need no scan:
// they go from the idle state straight to the commit step. The next item can be
// taken in the cycle after any result is loaded, when the controller is idle again.
// A new item is taken as soon as the previous one has been committed, even while
// its result still waits in the result register. Armed bits and health reset at
// once; no clearing pass runs after reset.
// Depends on mws_pkg, mws_in_if, mws_out_if, mws_ctrl and mws_datapath.
module multi_watchdog_supervisor #(
  parameter int NUM_SLOTS   = 8,
  parameter int NUM_DOMAINS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  mws_in_if.sink    in_ch,
  mws_out_if.source out_ch
);
  import mws_pkg::*;

  item_t item;
  cmd_t  cmd;
  sts_t  sts;
  logic  in_ready;

  // Gather the input payload.
  assign item.op           = in_ch.op;
  assign item.dog_id       = in_ch.dog_id;
  assign item.now_tick     = in_ch.now_tick;
  assign item.limit_ticks  = in_ch.limit_ticks;
  assign item.fault_domain = in_ch.fault_domain;
  assign item.new_health   = in_ch.new_health;
  assign in_ch.ready       = in_ready;

  mws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mws_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_DOMAINS (NUM_DOMAINS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .out_ch (out_ch)
  );

endmodule
